// ----- design/ctrnn_euler_step_defines.svh -----
// assertion macros used by the port-level checker
`ifndef CTRNN_EULER_STEP_DEFINES_SVH
`define CTRNN_EULER_STEP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CTRNN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define CTRNN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ctrnn_pkg.sv -----
// shared types, constants and sigmoid table for the ctrnn euler step block
package ctrnn_pkg;

    localparam int NEURONS    = 8;
    localparam int SIG_DEPTH  = 256;
    localparam int SIG_DL     = $clog2(SIG_DEPTH);
    localparam int NW         = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int WDEPTH     = NEURONS * NEURONS;
    localparam int WAW        = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int MAXN       = (NEURONS < 8) ? NEURONS : 8;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 1;

    // item kinds
    localparam logic [2:0] KIND_WEIGHT = 3'd0;
    localparam logic [2:0] KIND_BIAS   = 3'd1;
    localparam logic [2:0] KIND_ITAU   = 3'd2;
    localparam logic [2:0] KIND_VOLT   = 3'd3;
    localparam logic [2:0] KIND_EXT    = 3'd4;
    localparam logic [2:0] KIND_STEP   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEURONS   = 1'd1;

    localparam logic [15:0] STEP_SIZE_RESET = 16'd655;
    localparam logic [3:0]  NIU_RESET       = 4'(MAXN);

    // controller to datapath commands
    typedef struct packed {
        logic          wr_en;
        logic          acc_load;
        logic          mac_issue;
        logic          net_en;
        logic          mul_en;
        logic          upd_en;
        logic          emit_en;
        logic          emit_last;
        logic [NW-1:0] idx_i;
        logic [NW-1:0] idx_j;
    } ctrnn_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [3:0] n_active;
    } ctrnn_sts_t;

    typedef logic [SIG_DEPTH-1:0][15:0] sig_tab_t;

    // saturate a signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
        logic signed [15:0] r;
        if (x > 20'sd32767) r = 16'sh7fff;
        else if (x < -20'sd32768) r = 16'sh8000;
        else r = x[15:0];
        return r;
    endfunction

    // sigmoid table at bin centers, evaluated at elaboration
    function automatic sig_tab_t build_sig_table();
        logic [63:0] eb [15];
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        int          c;
        int          a;
        sig_tab_t    tab;
        t = (64'd1 << 60) - (64'd1 << 50) + (64'd1 << 39) - 64'd178956970 + 64'd43690;
        eb[0] = (t + (64'd1 << 27)) >> 28;
        for (int b = 1; b < 15; b++) begin
            eb[b] = (eb[b-1] * eb[b-1] + (64'd1 << 31)) >> 32;
        end
        for (int k = 0; k < SIG_DEPTH; k++) begin
            c = -16384 + ((2 * k + 1) * 16384) / SIG_DEPTH;
            a = (c < 0) ? -c : c;
            e = 64'd1 << 32;
            for (int b = 0; b < 15; b++) begin
                if (a[b]) e = (e * eb[b] + (64'd1 << 31)) >> 32;
            end
            den = (64'd1 << 32) + e;
            if (c >= 0) num = (64'd1 << 48) + (den >> 1);
            else num = (e << 16) + (den >> 1);
            // long division, one quotient bit a pass
            q = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= den) begin
                    rem = rem - den;
                    q[b] = 1'b1;
                end
            end
            if (q > 64'd65535) q = 64'd65535;
            tab[k] = q[15:0];
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ----- design/ctrnn_ctrl.sv -----
// step sequencer: accepts items and walks the neuron and weight loops
module ctrnn_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2:0]            s_kind,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output ctrnn_pkg::ctrnn_cmd_t cmd,
    input  ctrnn_pkg::ctrnn_sts_t sts
);
    import ctrnn_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_MAC   = 4'd2;
    localparam logic [3:0] ST_DRAIN = 4'd3;
    localparam logic [3:0] ST_NET   = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_EMIT  = 4'd7;
    localparam logic [3:0] ST_HOLD  = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] j_reg, j_next;
    logic [NW-1:0] last_idx;
    logic          accept;

    assign last_idx = NW'(sts.n_active - 4'd1);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_HOLD);
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cmd           = '0;
        cmd.idx_i     = i_reg;
        cmd.idx_j     = j_reg;
        cmd.emit_last = (i_reg == last_idx);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_STEP) begin
                        state_next = ST_INIT;
                        i_next     = '0;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                cmd.acc_load = 1'b1;
                j_next       = '0;
                state_next   = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (j_reg == last_idx) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_NET;
            end
            ST_NET: begin
                cmd.net_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd_en = 1'b1;
                if (i_reg == last_idx) begin
                    i_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_EMIT: begin
                cmd.emit_en = 1'b1;
                state_next  = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_tready) begin
                    if (i_reg == last_idx) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

// ----- design/ctrnn_dp.sv -----
// datapath: stores, weight memory, shared mac, update and sigmoid lookup
module ctrnn_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ctrnn_pkg::ctrnn_cmd_t   cmd,
    output ctrnn_pkg::ctrnn_sts_t   sts,
    input  logic [2:0]              in_kind,
    input  logic [2:0]              in_row,
    input  logic [2:0]              in_col,
    input  logic signed [15:0]      in_value,
    input  logic                    cfg_valid,
    input  logic [ctrnn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]             cfg_data,
    output logic [2:0]              out_neuron,
    output logic [15:0]             out_activation,
    output logic                    out_last
);
    import ctrnn_pkg::*;

    logic [15:0]        step_size_reg;
    logic [3:0]         niu_reg;
    logic [3:0]         niu_clamped;

    logic signed [15:0] wmem [WDEPTH];
    logic [WDEPTH-1:0]  wvalid_reg;
    logic signed [15:0] wrd_reg;
    logic               wrd_valid_reg;
    logic               issue_reg;
    logic [NW-1:0]      jq_reg;

    logic signed [15:0] bias_reg  [NEURONS];
    logic [15:0]        itau_reg  [NEURONS];
    logic signed [15:0] volt_reg  [NEURONS];
    logic [15:0]        act_reg   [NEURONS];
    logic signed [15:0] ext_reg   [NEURONS];
    logic signed [15:0] newv_reg  [NEURONS];

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [16:0]      diff_reg;
    logic [31:0]             scale_reg;
    logic signed [48:0]      prod_reg;

    logic [NW-1:0]      row_n;
    logic               row_ok;
    logic               col_ok;
    logic [WAW-1:0]     wr_addr;
    logic [WAW-1:0]     rd_addr;
    logic signed [15:0] wterm;
    logic signed [32:0] mac_prod;
    logic signed [ACC_W-1:0] acc_round;
    logic signed [15:0] net_val;
    logic signed [48:0] delta_full;
    logic signed [19:0] vsum;
    logic [NW-1:0]      bias_idx;
    logic signed [16:0] sig_arg;
    logic signed [16:0] sig_clamp;
    logic [14:0]        sig_off;
    logic [15:0]        sig_val;

    assign row_n   = NW'(in_row);
    assign row_ok  = (int'(in_row) < NEURONS);
    assign col_ok  = (int'(in_col) < NEURONS);
    assign wr_addr = WAW'(int'(in_row) * NEURONS + int'(in_col));
    assign rd_addr = WAW'(int'(cmd.idx_j) * NEURONS + int'(cmd.idx_i));
    assign sts.n_active = niu_reg;

    // active count clamp
    always_comb begin
        niu_clamped = cfg_data[3:0];
        if (niu_clamped == 4'd0) niu_clamped = 4'd1;
        if (niu_clamped > NIU_RESET) niu_clamped = NIU_RESET;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_SIZE_RESET;
            niu_reg       <= NIU_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STEP_SIZE: step_size_reg <= cfg_data;
                CFG_NEURONS:   niu_reg <= niu_clamped;
                default: ;
            endcase
        end
    end

    // weight memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && in_kind == KIND_WEIGHT && row_ok && col_ok) begin
            wmem[wr_addr] <= in_value;
        end
        wrd_reg <= wmem[rd_addr];
    end

    // weight valid bits and read pipeline flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg    <= '0;
            wrd_valid_reg <= 1'b0;
            issue_reg     <= 1'b0;
        end else begin
            if (cmd.wr_en && in_kind == KIND_WEIGHT && row_ok && col_ok) begin
                wvalid_reg[wr_addr] <= 1'b1;
            end
            wrd_valid_reg <= wvalid_reg[rd_addr];
            issue_reg     <= cmd.mac_issue;
        end
    end

    always_ff @(posedge aclk) begin
        jq_reg <= cmd.idx_j;
    end

    // multiply-accumulate on the registered weight
    assign wterm    = wrd_valid_reg ? wrd_reg : 16'sd0;
    assign mac_prod = wterm * $signed({1'b0, act_reg[jq_reg]});

    // net input rounding and saturation
    assign acc_round = (acc_reg + ACC_W'(32768)) >>> 16;
    always_comb begin
        if (acc_round > ACC_W'(32767)) net_val = 16'sh7fff;
        else if (acc_round < -ACC_W'(32768)) net_val = 16'sh8000;
        else net_val = acc_round[15:0];
    end

    // euler increment
    assign delta_full = (prod_reg + 49'sd1073741824) >>> 31;
    assign vsum = 20'(volt_reg[cmd.idx_i]) + 20'($signed(delta_full[17:0]));

    // sigmoid lookup, shared by voltage writes and the step commit
    assign bias_idx = cmd.emit_en ? cmd.idx_i : row_n;
    assign sig_arg  = cmd.emit_en
        ? 17'(newv_reg[cmd.idx_i]) + 17'(bias_reg[bias_idx])
        : 17'(in_value) + 17'(bias_reg[bias_idx]);
    always_comb begin
        if (sig_arg < -17'sd16384) sig_clamp = -17'sd16384;
        else if (sig_arg > 17'sd16383) sig_clamp = 17'sd16383;
        else sig_clamp = sig_arg;
    end
    assign sig_off = 15'(sig_clamp + 17'sd16384);
    assign sig_val = SIG_TABLE[sig_off[14 -: SIG_DL]];

    // arithmetic pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.acc_load) begin
            acc_reg <= ACC_W'(ext_reg[cmd.idx_i]) <<< 16;
        end else if (issue_reg) begin
            acc_reg <= acc_reg + ACC_W'(mac_prod);
        end
        if (cmd.net_en) begin
            diff_reg  <= 17'(net_val) - 17'(volt_reg[cmd.idx_i]);
            scale_reg <= 32'(step_size_reg) * 32'(itau_reg[cmd.idx_i]);
        end
        if (cmd.mul_en) begin
            prod_reg <= $signed({1'b0, scale_reg}) * diff_reg;
        end
        if (cmd.upd_en) begin
            newv_reg[cmd.idx_i] <= sat16(vsum);
        end
    end

    // neuron stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NEURONS; k++) begin
                bias_reg[k] <= '0;
                itau_reg[k] <= '0;
                volt_reg[k] <= '0;
                act_reg[k]  <= '0;
                ext_reg[k]  <= '0;
            end
        end else if (cmd.emit_en) begin
            volt_reg[cmd.idx_i] <= newv_reg[cmd.idx_i];
            act_reg[cmd.idx_i]  <= sig_val;
        end else if (cmd.wr_en && row_ok) begin
            case (in_kind)
                KIND_BIAS: bias_reg[row_n] <= in_value;
                KIND_ITAU: itau_reg[row_n] <= in_value[15] ? 16'd0 : in_value;
                KIND_VOLT: begin
                    volt_reg[row_n] <= in_value;
                    act_reg[row_n]  <= sig_val;
                end
                KIND_EXT:  ext_reg[row_n] <= in_value;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit_en) begin
            out_neuron     <= 3'(cmd.idx_i);
            out_activation <= sig_val;
            out_last       <= cmd.emit_last;
        end
    end

endmodule

// ----- design/ctrnn_euler_step.sv -----
// Continuous-time recurrent network, Euler-integrated, with one shared MAC.
// Write items (kinds 0 to 4) give no result. A step item is accepted, then
// runs, per active neuron: a load, n weight MACs for n active neurons (one
// a cycle from a registered weight memory read), a drain, then net/diff,
// product and update steps; then each neuron is reported in turn, with any
// output stall holding the result. The shared MAC sets the rate.
module ctrnn_euler_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index[2:0], column_index[5:3], value[21:6]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // neuron[2:0], activation[18:3]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ctrnn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import ctrnn_pkg::*;

    ctrnn_cmd_t  cmd;
    ctrnn_sts_t  sts;
    logic [2:0]  out_neuron;
    logic [15:0] out_activation;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'd0, out_activation, out_neuron};

    // sequencer
    ctrnn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // arithmetic and storage
    ctrnn_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_kind        (s_tuser),
        .in_row         (s_tdata[2:0]),
        .in_col         (s_tdata[5:3]),
        .in_value       (s_tdata[21:6]),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_neuron     (out_neuron),
        .out_activation (out_activation),
        .out_last       (m_tlast)
    );

endmodule

// ----- design/ctrnn_chk.sv -----
// port-level checker for the ctrnn euler step block, with its bind
`include "ctrnn_euler_step_defines.svh"

module ctrnn_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    import ctrnn_pkg::*;

    // a held result keeps its valid
    `CTRNN_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    // a held result keeps its payload
    `CTRNN_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    // no new item is taken while a step still has results pending
    `CTRNN_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready)
    // an accepted step item closes the input until its results are out
    `CTRNN_ASSERT_NEXT(a_step_busy, s_tvalid && s_tready && s_tuser == KIND_STEP, !s_tready)
    // after a non-final result more results follow before new input
    `CTRNN_ASSERT_NEXT(a_more_follow, m_tvalid && m_tready && !m_tlast, !s_tready)

endmodule

bind ctrnn_euler_step ctrnn_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- dv/testbench.sv -----
// self-checking testbench for the ctrnn euler step block: stream driver, monitor and predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ctrnn_pkg::*;

    typedef struct {
        logic [2:0]         kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] value;
    } net_item_t;

    typedef struct {
        logic [2:0]  neuron;
        logic [15:0] act;
        logic        last;
    } activation_t;

    localparam int SETTLE_CYCLES = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    // model state of the network
    logic [15:0]        sig_tab [SIG_DEPTH];
    logic signed [15:0] w_mdl [NEURONS*NEURONS];
    logic signed [15:0] bias_mdl [NEURONS];
    logic signed [15:0] itau_mdl [NEURONS];
    logic signed [15:0] volt_mdl [NEURONS];
    logic [15:0]        act_mdl [NEURONS];
    logic signed [15:0] ext_mdl [NEURONS];
    logic [15:0]        step_mdl;
    logic [3:0]         active_mdl;

    net_item_t   item_q [$];
    activation_t act_exp_q [$];
    net_item_t   cur_item;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;
    int hold_cnt;
    int mismatches;
    int results_seen;
    int steps_sent;

    ctrnn_euler_step i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // sigmoid table built from exp constants in integer arithmetic
    function automatic void fill_sig_tab();
        longint unsigned eb [15];
        longint unsigned t, e, den, q;
        int c, a;
        t = (64'd1 << 60) - (64'd1 << 50) + (64'd1 << 39) - 64'd178956970 + 64'd43690;
        eb[0] = (t + (64'd1 << 27)) >> 28;
        for (int b = 1; b < 15; b++) eb[b] = (eb[b-1] * eb[b-1] + (64'd1 << 31)) >> 32;
        for (int k = 0; k < SIG_DEPTH; k++) begin
            c = -16384 + ((2 * k + 1) * 16384) / SIG_DEPTH;
            a = (c < 0) ? -c : c;
            e = 64'd1 << 32;
            for (int b = 0; b < 15; b++)
                if (a[b]) e = (e * eb[b] + (64'd1 << 31)) >> 32;
            den = (64'd1 << 32) + e;
            if (c >= 0) q = ((64'd1 << 48) + den / 2) / den;
            else q = ((e << 16) + den / 2) / den;
            if (q > 64'd65535) q = 64'd65535;
            sig_tab[k] = q[15:0];
        end
    endfunction

    function automatic logic [15:0] sigmoid_of(int x);
        int idx;
        if (x < -16384) x = -16384;
        if (x > 16383) x = 16383;
        idx = ((x + 16384) * SIG_DEPTH) / 32768;
        if (idx >= SIG_DEPTH) idx = SIG_DEPTH - 1;
        return sig_tab[idx];
    endfunction

    function automatic logic signed [15:0] clip16(longint x);
        if (x > 32767) return 16'sh7fff;
        if (x < -32768) return 16'sh8000;
        return x[15:0];
    endfunction

    // apply one accepted item to the model, queue the activations a step reports
    function automatic void advance_network(net_item_t it);
        logic signed [15:0] nv [NEURONS];
        longint acc, net, diff, prod, delta;
        int n;
        activation_t r;
        case (it.kind)
            KIND_WEIGHT: w_mdl[it.row * NEURONS + it.col] = it.value;
            KIND_BIAS:   bias_mdl[it.row] = it.value;
            KIND_ITAU:   itau_mdl[it.row] = (it.value < 0) ? 16'sd0 : it.value;
            KIND_VOLT: begin
                volt_mdl[it.row] = it.value;
                act_mdl[it.row] = sigmoid_of(int'(it.value) + int'(bias_mdl[it.row]));
            end
            KIND_EXT:    ext_mdl[it.row] = it.value;
            KIND_STEP: begin
                n = active_mdl;
                if (n < 1) n = 1;
                if (n > MAXN) n = MAXN;
                for (int i = 0; i < n; i++) begin
                    acc = longint'(ext_mdl[i]) * 65536;
                    for (int j = 0; j < n; j++)
                        acc += longint'(w_mdl[j * NEURONS + i]) * longint'({1'b0, act_mdl[j]});
                    net = clip16((acc + (64'sd1 <<< 15)) >>> 16);
                    diff = net - longint'(volt_mdl[i]);
                    prod = longint'({1'b0, step_mdl}) * longint'({1'b0, itau_mdl[i]}) * diff;
                    delta = (prod + (64'sd1 <<< 30)) >>> 31;
                    nv[i] = clip16(longint'(volt_mdl[i]) + delta);
                end
                for (int i = 0; i < n; i++) begin
                    volt_mdl[i] = nv[i];
                    act_mdl[i] = sigmoid_of(int'(nv[i]) + int'(bias_mdl[i]));
                    r.neuron = i[2:0];
                    r.act = act_mdl[i];
                    r.last = (i + 1 == n);
                    act_exp_q.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // input driver fed from the pending item queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_network(cur_item);
                if (cur_item.kind == KIND_STEP) steps_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, cur_item.value, cur_item.col, cur_item.row};
                    s_tuser <= cur_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor with random stalls and long hold-offs
    always @(posedge aclk) begin
        activation_t ex;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (act_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: neuron %0d act %h last %b",
                                 m_tdata[2:0], m_tdata[18:3], m_tlast);
                end else begin
                    ex = act_exp_q.pop_front();
                    if (m_tdata[2:0] !== ex.neuron || m_tdata[18:3] !== ex.act ||
                        m_tlast !== ex.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp neuron %0d act %h last %b, got %0d %h %b",
                                     ex.neuron, ex.act, ex.last,
                                     m_tdata[2:0], m_tdata[18:3], m_tlast);
                    end
                end
            end
            if (hold_req > 0) begin
                hold_cnt <= hold_req;
                hold_req = 0;
                m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_STEP_SIZE) step_mdl = data;
        else active_mdl = data[3:0];
    endtask

    task automatic add_item(logic [2:0] k, logic [2:0] r, logic [2:0] c, logic [15:0] v);
        net_item_t it;
        it.kind = k;
        it.row = r;
        it.col = c;
        it.value = v;
        item_q.push_back(it);
    endtask

    // random value, often in a moderate range so the network stays lively
    function automatic logic [15:0] rand_value();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(4096)) - 2048);
    endfunction

    // well-formed bursts of writes followed by a step, with some noise
    task automatic add_random(int count);
        int left;
        left = count;
        while (left > 0) begin
            for (int w = $urandom_range(6); w > 0 && left > 0; w--) begin
                if ($urandom_range(19) == 0)
                    add_item(3'($urandom_range(7, 6)), 3'($urandom), 3'($urandom), 16'($urandom));
                else
                    add_item(3'($urandom_range(4)), 3'($urandom), 3'($urandom), rand_value());
                left--;
            end
            add_item(KIND_STEP, 3'($urandom), 3'($urandom), 16'($urandom));
            left--;
        end
    endtask

    task automatic drain();
        while (item_q.size() > 0 || s_tvalid || act_exp_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // stimulus and phases
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 38;
        recv_idle_pct = 88;
        hold_req = 0;
        mismatches = 0;
        results_seen = 0;
        steps_sent = 0;
        fill_sig_tab();
        for (int i = 0; i < NEURONS * NEURONS; i++) w_mdl[i] = '0;
        for (int i = 0; i < NEURONS; i++) begin
            bias_mdl[i] = '0;
            itau_mdl[i] = '0;
            volt_mdl[i] = '0;
            act_mdl[i] = '0;
            ext_mdl[i] = '0;
        end
        step_mdl = STEP_SIZE_RESET;
        active_mdl = NIU_RESET;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: step on reset state, then field extremes and every kind
        add_item(KIND_STEP, 3'd0, 3'd0, 16'h0000);
        add_item(KIND_WEIGHT, 3'd7, 3'd7, 16'h8000);
        add_item(KIND_WEIGHT, 3'd0, 3'd7, 16'h7fff);
        add_item(KIND_WEIGHT, 3'd7, 3'd0, 16'h0400);
        add_item(KIND_ITAU, 3'd0, 3'd5, 16'h8000);
        add_item(KIND_ITAU, 3'd7, 3'd0, 16'h7fff);
        add_item(KIND_ITAU, 3'd3, 3'd0, 16'hffff);
        add_item(KIND_BIAS, 3'd7, 3'd2, 16'h7fff);
        add_item(KIND_BIAS, 3'd1, 3'd0, 16'h8000);
        add_item(KIND_VOLT, 3'd7, 3'd0, 16'h7fff);
        add_item(KIND_VOLT, 3'd1, 3'd3, 16'h8000);
        add_item(KIND_VOLT, 3'd2, 3'd0, 16'h0000);
        add_item(KIND_EXT, 3'd7, 3'd0, 16'h7fff);
        add_item(KIND_EXT, 3'd0, 3'd1, 16'h8000);
        add_item(3'd6, 3'd7, 3'd7, 16'hffff);
        add_item(3'd7, 3'd0, 3'd0, 16'h1234);
        add_item(KIND_STEP, 3'd7, 3'd7, 16'hffff);
        add_item(KIND_STEP, 3'd0, 3'd0, 16'h0000);
        drain();

        // phase one: slow receiver, and a long receiver hold-off fills the block
        write_reg(CFG_STEP_SIZE, 16'hffff);
        write_reg(CFG_NEURONS, 16'd8);
        add_random(40);
        hold_req = 600;
        drain();
        write_reg(CFG_STEP_SIZE, 16'h0000);
        write_reg(CFG_NEURONS, 16'd0);
        add_random(30);
        drain();

        // phase two: roles swapped
        send_idle_pct = 88;
        recv_idle_pct = 38;
        write_reg(CFG_STEP_SIZE, 16'($urandom));
        write_reg(CFG_NEURONS, 16'd15);
        add_random(40);
        drain();
        write_reg(CFG_NEURONS, 16'd1);
        add_random(30);
        drain();

        // phase three: no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_STEP_SIZE, 16'd655);
        write_reg(CFG_NEURONS, 16'($urandom_range(1, 8)));
        add_random(50);
        drain();
        write_reg(CFG_STEP_SIZE, 16'($urandom));
        write_reg(CFG_NEURONS, 16'd8);
        add_random(50);
        drain();

        $display("covered %0d step items and %0d reported activations", steps_sent, results_seen);
        $display("configs: step sizes 0, max, reset and random; active counts 0 to 15");
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end

    // run-time limit
    initial begin
        #4000000;
        $display("timeout");
        $display("testbench: FAIL");
        $finish;
    end
endmodule

// ----- ctrnn_euler_step.f -----
+incdir+design
design/ctrnn_pkg.sv
design/ctrnn_ctrl.sv
design/ctrnn_dp.sv
design/ctrnn_euler_step.sv
design/ctrnn_chk.sv
dv/testbench.sv
